// File: hdl/glcm_pkg.sv
// ----------------------------------------------------------------------------
// glcm_pkg: shared types and constants of the co-occurrence accumulator
// Geometry limits, op codes, config register indexes and the command that
// travels from the front end to the matrix engine.
// ----------------------------------------------------------------------------
package glcm_pkg;

  localparam int MAX_WIDTH      = 512;
  localparam int MAX_HEIGHT     = 512;
  localparam int MAX_STEP       = 4;
  localparam int GREY_LEVELS    = 256;
  localparam int MAX_DIRECTIONS = 4;
  localparam int LINE_ROWS      = MAX_STEP + 1;

  localparam int CW  = 20;
  localparam int DW  = 2;
  localparam int LW  = 8;
  localparam int PW  = 10;
  localparam int CAW = DW + 2 * LW;
  localparam int LSW = $clog2(LINE_ROWS * MAX_WIDTH);
  localparam int LSD = LINE_ROWS * MAX_WIDTH;
  localparam int CSD = MAX_DIRECTIONS * GREY_LEVELS * GREY_LEVELS;
  localparam int QDEPTH = 4;
  localparam int QAW = 2;

  localparam logic [CW-1:0] COUNT_MAX = '1;

  localparam logic [1:0] OP_PIXEL  = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [2:0] REG_WIDTH  = 3'd0;
  localparam logic [2:0] REG_HEIGHT = 3'd1;
  localparam logic [2:0] REG_STEP   = 3'd2;
  localparam logic [2:0] REG_DCOUNT = 3'd3;
  localparam logic [2:0] REG_DSET   = 3'd4;

  typedef enum logic [1:0] {
    CMD_PAIR,
    CMD_READ,
    CMD_CLEAR
  } cmd_kind_t;

  // one pair increment, one read or one clear, already classified
  typedef struct packed {
    cmd_kind_t     kind;
    logic [DW-1:0] dir;
    logic [LW-1:0] a;
    logic [LW-1:0] b;
    logic          dbl;  // a == b entry, bump once by two
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_RD1,
    BK_WR1,
    BK_RD2,
    BK_WR2,
    BK_RDOUT,
    BK_CLEAR,
    BK_OUT
  } bk_state_t;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_LOOK,
    FR_PAIR
  } fr_state_t;

  function automatic logic signed [4:0] step_of(input logic [1:0] code,
                                                input logic [2:0] m);
    logic signed [4:0] mm;
    mm = signed'({2'b00, m});
    if (code == 2'd1) return mm;
    else if (code == 2'd3) return -mm;
    else return 5'sd0;
  endfunction

  function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] v,
                                            input logic [1:0] n);
    logic [CW:0] s;
    s = {1'b0, v} + {{(CW-1){1'b0}}, n};
    return s[CW] ? COUNT_MAX : s[CW-1:0];
  endfunction

endpackage

// File: hdl/glcm_ram.sv
// ----------------------------------------------------------------------------
// glcm_ram: generic single-port RAM
// One write or one read a cycle, registered read data.
// ----------------------------------------------------------------------------
module glcm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: hdl/glcm_front.sv
// ----------------------------------------------------------------------------
// glcm_front: input classifier
// Tracks the raster position, keeps the line store, and turns each pixel
// into one pair command per in-bounds direction; passes reads and clears.
// ----------------------------------------------------------------------------
module glcm_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           op,
  input  logic [7:0]           pixel,
  input  logic [1:0]           direction,
  input  logic [7:0]           level_a,
  input  logic [7:0]           level_b,
  input  logic [9:0]           cfg_w,
  input  logic [9:0]           cfg_h,
  input  logic [2:0]           cfg_m,
  input  logic [2:0]           cfg_nd,
  input  logic [15:0]          cfg_set,
  output logic                 cmd_valid,
  input  logic                 cmd_full,
  output glcm_pkg::cmd_t       cmd
);

  glcm_pkg::fr_state_t state, state_next;
  logic [8:0]  col, row;
  logic [7:0]  a;
  logic [1:0]  d;
  logic        ls_we;
  logic [glcm_pkg::LSW-1:0] ls_addr;
  logic [7:0]  ls_rdata;
  logic signed [11:0] pr, pc;
  logic signed [4:0]  dr, dc, dr0, dc0;
  logic        inb, zero_off, last_dir;
  logic [2:0]  row_mod;

  // geometry clamp
  logic [9:0] w_eff, h_eff;
  logic [2:0] nd_eff;
  logic [2:0] m_eff;
  always_comb begin
    w_eff  = (cfg_w == 10'd0) ? 10'd1 : (cfg_w > 10'(glcm_pkg::MAX_WIDTH))
             ? 10'(glcm_pkg::MAX_WIDTH) : cfg_w;
    h_eff  = (cfg_h == 10'd0) ? 10'd1 : (cfg_h > 10'(glcm_pkg::MAX_HEIGHT))
             ? 10'(glcm_pkg::MAX_HEIGHT) : cfg_h;
    m_eff  = (cfg_m == 3'd0) ? 3'd1 : (cfg_m > 3'(glcm_pkg::MAX_STEP))
             ? 3'(glcm_pkg::MAX_STEP) : cfg_m;
    nd_eff = (cfg_nd == 3'd0) ? 3'd1 : (cfg_nd > 3'(glcm_pkg::MAX_DIRECTIONS))
             ? 3'(glcm_pkg::MAX_DIRECTIONS) : cfg_nd;
  end

  // offset of current direction, folded to point backward
  always_comb begin
    dr0 = glcm_pkg::step_of(cfg_set[4*d +: 2], m_eff);
    dc0 = glcm_pkg::step_of(cfg_set[4*d+2 +: 2], m_eff);
    if (dr0 > 0 || (dr0 == 0 && dc0 > 0)) begin
      dr = -dr0;
      dc = -dc0;
    end else begin
      dr = dr0;
      dc = dc0;
    end
    pr = signed'({3'b000, row}) + 12'(dr);
    pc = signed'({3'b000, col}) + 12'(dc);
    inb = (pr >= 0) && (pc >= 0) && (pc < signed'({2'b00, w_eff}))
          && (pr < signed'({2'b00, h_eff}));
    zero_off = (dr == 0) && (dc == 0);
    last_dir = ({1'b0, d} + 3'd1) >= nd_eff;
  end

  // row modulo line rows, tracked incrementally
  logic [2:0] pm;
  always_comb begin
    // backward rows: row_mod minus |dr|, wrapped
    if ({1'b0, row_mod} >= 4'(-dr)) pm = row_mod - 3'(-dr);
    else pm = 3'(4'(row_mod) + 4'(glcm_pkg::LINE_ROWS) - 4'(-dr));
  end

  always_comb begin
    ls_we   = 1'b0;
    ls_addr = glcm_pkg::LSW'(pm) * glcm_pkg::LSW'(glcm_pkg::MAX_WIDTH)
              + glcm_pkg::LSW'(pc[8:0]);
    if (state == glcm_pkg::FR_PAIR && last_dir && !cmd_full) begin
      ls_we   = 1'b1;
      ls_addr = glcm_pkg::LSW'(row_mod) * glcm_pkg::LSW'(glcm_pkg::MAX_WIDTH)
                + glcm_pkg::LSW'(col);
    end
  end

  glcm_ram #(.WIDTH(8), .DEPTH(glcm_pkg::LSD)) u_line (
    .clk(clk), .we(ls_we), .addr(ls_addr), .wdata(a), .rdata(ls_rdata)
  );

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    cmd_valid  = 1'b0;
    cmd.kind   = glcm_pkg::CMD_PAIR;
    cmd.dir    = d;
    cmd.a      = a;
    cmd.b      = zero_off ? a : ls_rdata;
    cmd.dbl    = zero_off || (cmd.b == a);
    unique case (state)
      glcm_pkg::FR_IDLE: begin
        in_stall = cmd_full;
        cmd.kind = (op == glcm_pkg::OP_READ) ? glcm_pkg::CMD_READ
                   : glcm_pkg::CMD_CLEAR;
        cmd.dir  = direction;
        cmd.a    = level_a;
        cmd.b    = level_b;
        cmd.dbl  = 1'b0;
        if (in_valid && !cmd_full) begin
          if (op == glcm_pkg::OP_READ || op == glcm_pkg::OP_CLEAR) begin
            cmd_valid = 1'b1;
          end else if (op == glcm_pkg::OP_PIXEL) begin
            state_next = glcm_pkg::FR_LOOK;
          end
        end
      end
      glcm_pkg::FR_LOOK: begin
        state_next = glcm_pkg::FR_PAIR;
      end
      glcm_pkg::FR_PAIR: begin
        if (!cmd_full) begin
          cmd_valid  = inb;
          state_next = last_dir ? glcm_pkg::FR_IDLE : glcm_pkg::FR_LOOK;
        end
      end
      default: state_next = glcm_pkg::FR_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= glcm_pkg::FR_IDLE;
      col     <= '0;
      row     <= '0;
      row_mod <= '0;
      d       <= '0;
    end else begin
      state <= state_next;
      if (state == glcm_pkg::FR_IDLE && in_valid && !cmd_full
          && op == glcm_pkg::OP_PIXEL) begin
        a <= pixel;
        d <= '0;
      end
      if (state == glcm_pkg::FR_PAIR && !cmd_full) begin
        d <= d + 2'd1;
        if (last_dir) begin
          if ({1'b0, col} + 10'd1 >= w_eff) begin
            col <= '0;
            if ({1'b0, row} + 10'd1 >= h_eff) begin
              row     <= '0;
              row_mod <= '0;
            end else begin
              row     <= row + 9'd1;
              row_mod <= (row_mod == 3'(glcm_pkg::LINE_ROWS - 1)) ? 3'd0
                         : row_mod + 3'd1;
            end
          end else begin
            col <= col + 9'd1;
          end
        end
      end
    end
  end

endmodule

// File: hdl/glcm_queue.sv
// ----------------------------------------------------------------------------
// glcm_queue: command queue between classifier and matrix engine
// Small register FIFO; full and empty flags come from a fill count.
// ----------------------------------------------------------------------------
module glcm_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  glcm_pkg::cmd_t wdata,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output glcm_pkg::cmd_t rdata
);

  glcm_pkg::cmd_t slots [glcm_pkg::QDEPTH];
  logic [glcm_pkg::QAW-1:0] wptr, rptr;
  logic [glcm_pkg::QAW:0]   fill;

  assign full  = (fill == (glcm_pkg::QAW+1)'(glcm_pkg::QDEPTH));
  assign empty = (fill == '0);
  assign rdata = slots[rptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push && !full) wptr <= wptr + 1'b1;
      if (pop && !empty) rptr <= rptr + 1'b1;
      fill <= fill + ((push && !full) ? 1'b1 : 1'b0) - ((pop && !empty) ? 1'b1 : 1'b0);
    end
  end

endmodule

// File: hdl/glcm_back.sv
// ----------------------------------------------------------------------------
// glcm_back: matrix engine
// Executes pair increments as read-modify-write on the count store, serves
// reads, and sweeps the store clear after reset and on a clear command.
// ----------------------------------------------------------------------------
module glcm_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_empty,
  input  glcm_pkg::cmd_t              q_cmd,
  output logic                        q_pop,
  output logic                        busy_clear,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [glcm_pkg::CW-1:0]     pair_count,
  output logic [glcm_pkg::CW-1:0]     direction_total
);

  glcm_pkg::bk_state_t state, state_next;
  glcm_pkg::cmd_t      cur;
  logic [glcm_pkg::CW-1:0] totals [glcm_pkg::MAX_DIRECTIONS];
  logic [glcm_pkg::CAW-1:0] clr_addr;
  logic        we;
  logic [glcm_pkg::CAW-1:0] addr;
  logic [glcm_pkg::CW-1:0]  wdata, rdata;
  logic        out_load;

  assign busy_clear = (state == glcm_pkg::BK_CLEAR);

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    we         = 1'b0;
    wdata      = glcm_pkg::sat_add(rdata, cur.dbl ? 2'd2 : 2'd1);
    addr       = {cur.dir, cur.a, cur.b};
    out_load   = 1'b0;
    unique case (state)
      glcm_pkg::BK_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          unique case (q_cmd.kind)
            glcm_pkg::CMD_PAIR:  state_next = glcm_pkg::BK_RD1;
            glcm_pkg::CMD_READ:  state_next = glcm_pkg::BK_RDOUT;
            glcm_pkg::CMD_CLEAR: state_next = glcm_pkg::BK_CLEAR;
            default:             state_next = glcm_pkg::BK_IDLE;
          endcase
        end
      end
      glcm_pkg::BK_RD1: state_next = glcm_pkg::BK_WR1;
      glcm_pkg::BK_WR1: begin
        we = 1'b1;
        state_next = cur.dbl ? glcm_pkg::BK_IDLE : glcm_pkg::BK_RD2;
      end
      glcm_pkg::BK_RD2: begin
        addr = {cur.dir, cur.b, cur.a};
        state_next = glcm_pkg::BK_WR2;
      end
      glcm_pkg::BK_WR2: begin
        addr = {cur.dir, cur.b, cur.a};
        we = 1'b1;
        state_next = glcm_pkg::BK_IDLE;
      end
      glcm_pkg::BK_RDOUT: begin
        // read data arrives next cycle
        state_next = glcm_pkg::BK_OUT;
      end
      glcm_pkg::BK_OUT: begin
        // hold the read address so the RAM output stays valid
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = glcm_pkg::BK_IDLE;
        end
      end
      glcm_pkg::BK_CLEAR: begin
        addr  = clr_addr;
        we    = 1'b1;
        wdata = '0;
        if (clr_addr == '1) state_next = glcm_pkg::BK_IDLE;
      end
      default: state_next = glcm_pkg::BK_IDLE;
    endcase
  end

  glcm_ram #(.WIDTH(glcm_pkg::CW), .DEPTH(glcm_pkg::CSD)) u_counts (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_cmd;
    if (out_load) begin
      pair_count      <= rdata;
      direction_total <= totals[cur.dir];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= glcm_pkg::BK_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < glcm_pkg::MAX_DIRECTIONS; i++) totals[i] <= '0;
    end else begin
      state <= state_next;
      if (state == glcm_pkg::BK_CLEAR) clr_addr <= clr_addr + 1'b1;
      if (q_pop && q_cmd.kind == glcm_pkg::CMD_CLEAR) begin
        clr_addr <= '0;
        for (int i = 0; i < glcm_pkg::MAX_DIRECTIONS; i++) totals[i] <= '0;
      end
      if (state == glcm_pkg::BK_WR1) begin
        totals[cur.dir] <= glcm_pkg::sat_add(totals[cur.dir], 2'd2);
      end
      if (out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

endmodule

// File: hdl/glcm_accumulator.sv
// ----------------------------------------------------------------------------
// glcm_accumulator: grey level co-occurrence matrix accumulator
// Builds symmetric pair-count matrices for up to four step directions.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) takes op, pixel, direction, level_a,
//   level_b. Pixel ops carry raster pixels; read ops return one item on the
//   output channel (out_valid/out_stall) with pair_count and direction_total;
//   clear ops zero all counts and totals.
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the
//   geometry and direction registers; write only while the block is idle.
// Timing:
//   A pixel holds the input through a lookup and a pair state per direction
//   in use; reads, clears and ignored ops are taken in the idle state. Each
//   in-bounds pair is one read-modify-write when a == b, else two, on one
//   single-port memory. A read passes the engine's read and output states.
//   A clear sweeps all 262144 count entries, one per cycle, as does reset;
//   input is stalled during the sweep and while the queue is full. When the
//   receiver stalls, the result holds in the output register and the engine
//   waits; the classifier keeps filling the queue.
// ----------------------------------------------------------------------------
module glcm_accumulator (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  op,
  input  logic [7:0]  pixel,
  input  logic [1:0]  direction,
  input  logic [7:0]  level_a,
  input  logic [7:0]  level_b,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [19:0] pair_count,
  output logic [19:0] direction_total,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [9:0]  image_width, image_height;
  logic [2:0]  step_magnitude, direction_count;
  logic [15:0] direction_set;
  logic        cmd_valid, q_full, q_empty, q_pop, busy_clear;
  glcm_pkg::cmd_t cmd, q_cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width     <= 10'd512;
      image_height    <= 10'd512;
      step_magnitude  <= 3'd1;
      direction_count <= 3'd4;
      direction_set   <= 16'd62324;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        glcm_pkg::REG_WIDTH:  image_width     <= cfg_data[9:0];
        glcm_pkg::REG_HEIGHT: image_height    <= cfg_data[9:0];
        glcm_pkg::REG_STEP:   step_magnitude  <= cfg_data[2:0];
        glcm_pkg::REG_DCOUNT: direction_count <= cfg_data[2:0];
        glcm_pkg::REG_DSET:   direction_set   <= cfg_data;
        default: ;
      endcase
    end
  end

  glcm_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .pixel(pixel), .direction(direction), .level_a(level_a),
    .level_b(level_b), .cfg_w(image_width), .cfg_h(image_height),
    .cfg_m(step_magnitude), .cfg_nd(direction_count), .cfg_set(direction_set),
    .cmd_valid(cmd_valid), .cmd_full(q_full || busy_clear), .cmd(cmd)
  );

  glcm_queue u_queue (
    .clk(clk), .rst(rst), .push(cmd_valid), .wdata(cmd), .full(q_full),
    .pop(q_pop), .empty(q_empty), .rdata(q_cmd)
  );

  glcm_back u_back (
    .clk(clk), .rst(rst), .q_empty(q_empty), .q_cmd(q_cmd), .q_pop(q_pop),
    .busy_clear(busy_clear), .out_valid(out_valid), .out_stall(out_stall),
    .pair_count(pair_count), .direction_total(direction_total)
  );

endmodule
